### hdl/sha256bc_pkg.sv
// SHA-256 block compressor: shared types, constants and mixing functions.
// Used by sha256bc_round and sha256_block_compressor_unit. No dependencies.
`default_nettype none

package sha256bc_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  localparam int RoundCount = 64;
  localparam int SchedDepth = 16;

  // Standard initial hash values, A first.
  localparam hash_t HashInit = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

### hdl/sha256bc_round.sv
// One SHA-256 round: next working variables from current ones, W and K.
// Depends on sha256bc_pkg.
`default_nettype none

module sha256bc_round (
  input  var sha256bc_pkg::hash_t vars_in,
  input  var sha256bc_pkg::word_t w,
  input  var sha256bc_pkg::word_t k,
  output var sha256bc_pkg::hash_t vars_out
);

  sha256bc_pkg::word_t ch;
  sha256bc_pkg::word_t maj;
  sha256bc_pkg::word_t t1;
  sha256bc_pkg::word_t t2;

  assign ch  = vars_in[6] ^ (vars_in[4] & (vars_in[5] ^ vars_in[6]));
  assign maj = (vars_in[0] & vars_in[1]) | (vars_in[2] & (vars_in[0] | vars_in[1]));
  assign t1  = vars_in[7] + sha256bc_pkg::big_sigma1(vars_in[4]) + ch + k + w;
  assign t2  = sha256bc_pkg::big_sigma0(vars_in[0]) + maj;

  always_comb begin
    vars_out[0] = t1 + t2;
    vars_out[1] = vars_in[0];
    vars_out[2] = vars_in[1];
    vars_out[3] = vars_in[2];
    vars_out[4] = vars_in[3] + t1;
    vars_out[5] = vars_in[4];
    vars_out[6] = vars_in[5];
    vars_out[7] = vars_in[6];
  end

endmodule

`default_nettype wire

### hdl/sha256_block_compressor_unit.sv
// SHA-256 compression unit, top level. Depends on sha256bc_pkg, sha256bc_round.
// After the sixteenth word's transfer the unit runs the 64 rounds, then a chaining add,
// then strobes out the eight digest words, one word per cycle.
// Message words are taken one per cycle while idle; after the 16th the unit stays busy
// until its last digest word. The single round datapath does one round a cycle.
// Reset (rst, synchronous): chaining hash to the initial values, word count to zero, idle.
`default_nettype none

module sha256_block_compressor_unit (
  input  wire         clk,
  input  wire         rst,
  // command side
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] message_word,
  input  wire         new_message,
  // result side, one word per cycle, cannot be stalled
  output logic        digest_valid,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        last_word
);

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;  // collecting words
  localparam logic [1:0] StRound = 2'd1;  // 64 rounds, one per cycle
  localparam logic [1:0] StAdd   = 2'd2;  // fold working vars into chaining hash
  localparam logic [1:0] StOut   = 2'd3;  // strobe out the eight digest words

  logic [1:0] state;
  logic [5:0] cnt;         // round number, reused as digest index during output
  logic [3:0] word_count;  // words taken in the current block

  sha256bc_pkg::hash_t chain;
  sha256bc_pkg::hash_t vars;
  sha256bc_pkg::hash_t vars_next;
  sha256bc_pkg::word_t sched [sha256bc_pkg::SchedDepth];
  sha256bc_pkg::word_t sched_new;

  logic       accept;
  logic [3:0] count_eff;
  logic       block_full;

  assign busy   = (state != StIdle);
  assign accept = start && !busy;

  // A flagged word always opens a fresh block, so it can never complete one.
  assign count_eff  = new_message ? 4'd0 : word_count;
  assign block_full = (count_eff == 4'd15);

  // Rolling schedule: sched[0] always holds W for the current round;
  // the word sixteen rounds ahead is formed from fixed taps.
  assign sched_new = sha256bc_pkg::small_sigma1(sched[14]) + sched[9]
                   + sha256bc_pkg::small_sigma0(sched[1]) + sched[0];

  sha256bc_round u_round (
    .vars_in  (vars),
    .w        (sched[0]),
    .k        (sha256bc_pkg::RoundK[cnt]),
    .vars_out (vars_next)
  );

  // Control and chaining hash
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      cnt        <= '0;
      word_count <= '0;
      chain      <= sha256bc_pkg::HashInit;
    end else begin
      unique case (state)
        StIdle: begin
          if (accept) begin
            if (new_message) begin
              chain <= sha256bc_pkg::HashInit;
            end
            if (block_full) begin
              word_count <= '0;
              cnt        <= '0;
              state      <= StRound;
            end else begin
              word_count <= count_eff + 4'd1;
            end
          end
        end
        StRound: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(sha256bc_pkg::RoundCount - 1)) begin
            state <= StAdd;
          end
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          cnt   <= '0;
          state <= StOut;
        end
        StOut: begin
          cnt <= cnt + 6'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Datapath: schedule shift line and working variables (no reset needed)
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < sha256bc_pkg::SchedDepth - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256bc_pkg::SchedDepth - 1] <= message_word;
      if (block_full) begin
        vars <= chain;
      end
    end else if (state == StRound) begin
      for (int i = 0; i < sha256bc_pkg::SchedDepth - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256bc_pkg::SchedDepth - 1] <= sched_new;
      vars <= vars_next;
    end
  end

  // Result transfer straight from the chaining registers
  assign digest_valid = (state == StOut);
  assign digest_index = cnt[2:0];
  assign digest_word  = chain[cnt[2:0]];
  assign last_word    = (cnt[2:0] == 3'd7);

`ifndef SYNTHESIS
  // A completing word must start the compression in the next cycle.
  a_block_starts: assert property (@(posedge clk) disable iff (rst)
    accept && !new_message && word_count == 4'd15 |=> busy && !digest_valid)
    else $error("sixteenth word did not start compression");

  // Digest words come out back to back, in index order.
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !last_word |=> digest_valid
      && digest_index == $past(digest_index) + 3'd1)
    else $error("digest words out of order");

  // The run of digest words opens at word A.
  a_out_first: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> digest_index == 3'd0)
    else $error("digest run did not start at index 0");

  // After the last digest word the unit is ready again.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    digest_valid && last_word |=> !busy && !digest_valid)
    else $error("unit still busy after final digest word");
`endif

endmodule

`default_nettype wire
